>>> design/ptb_pkg.sv
// Shared types and constants for the palindromic tree builder.
// Used by the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

  localparam int NODE_CAPACITY = 4096;
  localparam int ALPHABET_SIZE = 32;
  localparam int TEXT_CAP      = NODE_CAPACITY - 2;
  localparam int NODE_W        = $clog2(NODE_CAPACITY);
  localparam int SYM_W         = $clog2(ALPHABET_SIZE);
  localparam int LEN_W         = NODE_W + 1;
  localparam int EDGE_DEPTH    = NODE_CAPACITY * ALPHABET_SIZE;

  localparam logic [NODE_W-1:0] ROOT_NEG  = NODE_W'(0);
  localparam logic [NODE_W-1:0] ROOT_ZERO = NODE_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WNODE,
    S_WTXT,
    S_EDGE,
    S_QCHK,
    S_CNT,
    S_OVF,
    S_EMIT
  } state_t;

  // One node record: length, suffix link, suffix count, parent and edge symbol.
  typedef struct packed {
    logic signed [LEN_W-1:0] len;
    logic [NODE_W-1:0]       link;
    logic [NODE_W-1:0]       cnt;
    logic [NODE_W-1:0]       parent;
    logic [SYM_W-1:0]        chr;
  } node_rec_t;

endpackage
`default_nettype wire

>>> design/ptb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> design/palindromic_tree_builder_top.sv
// Top level of the palindromic tree builder: control sequencer and three RAMs.
// Depends on ptb_pkg and ptb_ram.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per symbol. in_kind = 0
//   appends in_symbol to the text; in_kind = 1 restarts with an empty string.
//   Result channel (out_valid/out_ready): exactly one result per request,
//   in request order: longest palindromic suffix node, its length, the count
//   of palindromic suffixes ending here, a created flag and an overflow flag.
//   Rate: one request at a time. A restart goes straight to emit. An append
//   starts in idle, then checks each node of the suffix-link walk with a
//   node RAM read and then a text RAM read (the text read is skipped when the
//   check falls off the front of the text or lands on the length -1 root),
//   then does the edge lookup and hit check (the hit check is skipped when
//   the edge is empty) and ends in emit. A new node longer than 1 adds a
//   second walk, an edge lookup for its suffix link and, when that link is
//   not a root, a node read for its count. Hops are amortized constant.
//   The next request is taken as soon as the sequencer is back in idle, even
//   while the previous result still sits in the output register.
//   Reset: the tree returns to its two roots (length -1 and length 0). Edge
//   entries are never cleared; an edge counts only when the target node is
//   live and records this parent and symbol, so no clearing pass is needed.
//   Receiver stall: a finished result waits in the emit state until the
//   output register frees up; nothing is lost or dropped.
//   Capacity: at most NODE_CAPACITY-2 symbols; further appends are flagged.
`timescale 1ns / 1ps
`default_nettype none
module palindromic_tree_builder_top (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_kind,
  input  wire logic [4:0]               in_symbol,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [11:0]                   out_node_index,
  output logic [11:0]                   out_palindrome_length,
  output logic [11:0]                   out_suffix_palindrome_count,
  output logic                          out_created_node,
  output logic                          out_overflow
);

  localparam int NW = ptb_pkg::NODE_W;
  localparam int SW = ptb_pkg::SYM_W;
  localparam int LW = ptb_pkg::LEN_W;
  localparam int EAW = NW + SW;

  ptb_pkg::state_t state_r, state_nxt;

  // Tree-wide state
  logic [NW-1:0] pos_r, pos_nxt;
  logic [NW-1:0] last_r, last_nxt;
  logic [LW-1:0] total_r, total_nxt;

  // Per-request working registers
  logic [NW-1:0]        i_r, i_nxt;
  logic [SW-1:0]        c_r, c_nxt;
  logic [NW-1:0]        p_r, p_nxt;
  logic signed [LW-1:0] len_p_r, len_p_nxt;
  logic [NW-1:0]        link_p_r, link_p_nxt;
  logic                 phase2_r, phase2_nxt;
  logic [NW-1:0]        fresh_r, fresh_nxt;
  logic signed [LW-1:0] nl_r, nl_nxt;
  logic [NW-1:0]        par_r, par_nxt;
  logic [NW-1:0]        q_r, q_nxt;

  // Pending result
  logic [NW-1:0] res_node_r, res_node_nxt;
  logic [NW-1:0] res_len_r, res_len_nxt;
  logic [NW-1:0] res_cnt_r, res_cnt_nxt;
  logic          res_cre_r, res_cre_nxt;
  logic          res_ovf_r, res_ovf_nxt;

  // Output register
  logic          out_valid_r;
  logic [NW-1:0] out_node_r, out_len_r, out_cnt_r;
  logic          out_cre_r, out_ovf_r;
  logic          out_load;

  // RAM ports
  logic                node_we;
  logic [NW-1:0]       node_waddr, node_raddr;
  ptb_pkg::node_rec_t  node_wdata, node_rd;
  logic                text_we;
  logic [NW-1:0]       text_waddr, text_raddr;
  logic [SW-1:0]       text_wdata, text_rd;
  logic                edge_we;
  logic [EAW-1:0]      edge_waddr, edge_raddr;
  logic [NW-1:0]       edge_wdata, edge_rd;

  ptb_ram #(.WIDTH($bits(ptb_pkg::node_rec_t)), .DEPTH(ptb_pkg::NODE_CAPACITY)) u_node_ram (
    .clk    (clk),
    .wr_en  (node_we),
    .wr_addr(node_waddr),
    .wr_data(node_wdata),
    .rd_addr(node_raddr),
    .rd_data(node_rd)
  );

  ptb_ram #(.WIDTH(SW), .DEPTH(ptb_pkg::TEXT_CAP)) u_text_ram (
    .clk    (clk),
    .wr_en  (text_we),
    .wr_addr(text_waddr),
    .wr_data(text_wdata),
    .rd_addr(text_raddr),
    .rd_data(text_rd)
  );

  ptb_ram #(.WIDTH(NW), .DEPTH(ptb_pkg::EDGE_DEPTH)) u_edge_ram (
    .clk    (clk),
    .wr_en  (edge_we),
    .wr_addr(edge_waddr),
    .wr_data(edge_wdata),
    .rd_addr(edge_raddr),
    .rd_data(edge_rd)
  );

  // Root-aware view of the node record read last cycle for p_r
  logic signed [LW-1:0] len_p_cur;
  logic [NW-1:0]        link_p_cur;
  logic signed [LW+1:0] j_cur;
  logic                 full;
  logic                 q_live;
  logic [NW-1:0]        cnt_inc;

  always_comb begin
    if (p_r == ptb_pkg::ROOT_NEG) begin
      len_p_cur  = -LW'(1);
      link_p_cur = ptb_pkg::ROOT_NEG;
    end else if (p_r == ptb_pkg::ROOT_ZERO) begin
      len_p_cur  = '0;
      link_p_cur = ptb_pkg::ROOT_NEG;
    end else begin
      len_p_cur  = node_rd.len;
      link_p_cur = node_rd.link;
    end
    j_cur = $signed({3'b000, i_r}) - $signed({{2{len_p_cur[LW-1]}}, len_p_cur})
            - (LW+2)'(1);
  end

  assign full = (pos_r >= NW'(ptb_pkg::TEXT_CAP)) ||
                (total_r >= LW'(ptb_pkg::NODE_CAPACITY));
  assign q_live = (q_r >= NW'(2)) && ({1'b0, q_r} < total_r) &&
                  (node_rd.parent == p_r) && (node_rd.chr == c_r);
  assign cnt_inc = node_rd.cnt + NW'(1);

  assign out_load = (state_r == ptb_pkg::S_EMIT) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ptb_pkg::S_IDLE);

  always_comb begin
    logic hit, miss, do_create;
    logic [NW-1:0] miss_link;
    hit       = 1'b0;
    miss      = 1'b0;
    do_create = 1'b0;
    miss_link = link_p_r;

    state_nxt    = state_r;
    pos_nxt      = pos_r;
    last_nxt     = last_r;
    total_nxt    = total_r;
    i_nxt        = i_r;
    c_nxt        = c_r;
    p_nxt        = p_r;
    len_p_nxt    = len_p_r;
    link_p_nxt   = link_p_r;
    phase2_nxt   = phase2_r;
    fresh_nxt    = fresh_r;
    nl_nxt       = nl_r;
    par_nxt      = par_r;
    q_nxt        = q_r;
    res_node_nxt = res_node_r;
    res_len_nxt  = res_len_r;
    res_cnt_nxt  = res_cnt_r;
    res_cre_nxt  = res_cre_r;
    res_ovf_nxt  = res_ovf_r;

    node_we    = 1'b0;
    node_waddr = fresh_r;
    node_wdata = '0;
    node_raddr = p_r;
    text_we    = 1'b0;
    text_waddr = pos_r;
    text_wdata = in_symbol;
    text_raddr = j_cur[NW-1:0];
    edge_we    = 1'b0;
    edge_waddr = {par_r, c_r};
    edge_wdata = fresh_r;
    edge_raddr = {p_r, c_r};

    unique case (state_r)
      ptb_pkg::S_IDLE: begin
        if (in_valid) begin
          res_cre_nxt = 1'b0;
          res_ovf_nxt = 1'b0;
          if (in_kind) begin
            // Restart: drop back to the two roots
            pos_nxt      = '0;
            last_nxt     = ptb_pkg::ROOT_ZERO;
            total_nxt    = LW'(2);
            res_node_nxt = ptb_pkg::ROOT_ZERO;
            res_len_nxt  = '0;
            res_cnt_nxt  = '0;
            state_nxt    = ptb_pkg::S_EMIT;
          end else if (full) begin
            node_raddr = last_r;
            state_nxt  = ptb_pkg::S_OVF;
          end else begin
            text_we    = 1'b1;
            i_nxt      = pos_r;
            c_nxt      = in_symbol;
            pos_nxt    = pos_r + NW'(1);
            p_nxt      = last_r;
            node_raddr = last_r;
            phase2_nxt = 1'b0;
            state_nxt  = ptb_pkg::S_WNODE;
          end
        end
      end

      ptb_pkg::S_WNODE: begin
        len_p_nxt  = len_p_cur;
        link_p_nxt = link_p_cur;
        miss_link  = link_p_cur;
        if (p_r == ptb_pkg::ROOT_NEG) begin
          hit = 1'b1;
        end else if (j_cur[LW+1]) begin
          miss = 1'b1;
        end else begin
          state_nxt = ptb_pkg::S_WTXT;
        end
      end

      ptb_pkg::S_WTXT: begin
        if (text_rd == c_r) begin
          hit = 1'b1;
        end else begin
          miss = 1'b1;
        end
      end

      ptb_pkg::S_EDGE: begin
        if (!phase2_r) begin
          q_nxt = edge_rd;
          if (edge_rd == '0) begin
            do_create = 1'b1;
          end else begin
            node_raddr = edge_rd;
            state_nxt  = ptb_pkg::S_QCHK;
          end
        end else begin
          q_nxt = edge_rd;
          if (edge_rd < NW'(2)) begin
            node_we      = 1'b1;
            node_wdata   = '{len: nl_r, link: edge_rd, cnt: NW'(1), parent: par_r, chr: c_r};
            res_node_nxt = fresh_r;
            res_len_nxt  = nl_r[NW-1:0];
            res_cnt_nxt  = NW'(1);
            res_cre_nxt  = 1'b1;
            state_nxt    = ptb_pkg::S_EMIT;
          end else begin
            node_raddr = edge_rd;
            state_nxt  = ptb_pkg::S_CNT;
          end
        end
      end

      ptb_pkg::S_QCHK: begin
        if (q_live) begin
          last_nxt     = q_r;
          res_node_nxt = q_r;
          res_len_nxt  = node_rd.len[NW-1:0];
          res_cnt_nxt  = node_rd.cnt;
          res_cre_nxt  = 1'b0;
          state_nxt    = ptb_pkg::S_EMIT;
        end else begin
          do_create = 1'b1;
        end
      end

      ptb_pkg::S_CNT: begin
        node_we      = 1'b1;
        node_wdata   = '{len: nl_r, link: q_r, cnt: cnt_inc, parent: par_r, chr: c_r};
        res_node_nxt = fresh_r;
        res_len_nxt  = nl_r[NW-1:0];
        res_cnt_nxt  = cnt_inc;
        res_cre_nxt  = 1'b1;
        state_nxt    = ptb_pkg::S_EMIT;
      end

      ptb_pkg::S_OVF: begin
        res_node_nxt = last_r;
        res_ovf_nxt  = 1'b1;
        if (last_r < NW'(2)) begin
          res_len_nxt = '0;
          res_cnt_nxt = '0;
        end else begin
          res_len_nxt = node_rd.len[NW-1:0];
          res_cnt_nxt = node_rd.cnt;
        end
        state_nxt = ptb_pkg::S_EMIT;
      end

      ptb_pkg::S_EMIT: begin
        if (out_load) begin
          state_nxt = ptb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ptb_pkg::S_IDLE;
      end
    endcase

    // Suffix-link walk: advance on a miss, go to the edge lookup on a hit
    if (hit) begin
      edge_raddr = {p_r, c_r};
      state_nxt  = ptb_pkg::S_EDGE;
    end else if (miss) begin
      p_nxt      = miss_link;
      node_raddr = miss_link;
      state_nxt  = ptb_pkg::S_WNODE;
    end

    // New node: link it under p, then either finish or walk for its suffix link
    if (do_create) begin
      fresh_nxt  = total_r[NW-1:0];
      nl_nxt     = len_p_r + LW'(2);
      par_nxt    = p_r;
      edge_we    = 1'b1;
      edge_waddr = {p_r, c_r};
      edge_wdata = total_r[NW-1:0];
      total_nxt  = total_r + LW'(1);
      last_nxt   = total_r[NW-1:0];
      if (len_p_r == -LW'(1)) begin
        node_we      = 1'b1;
        node_waddr   = total_r[NW-1:0];
        node_wdata   = '{len: LW'(1), link: ptb_pkg::ROOT_ZERO, cnt: NW'(1),
                         parent: p_r, chr: c_r};
        res_node_nxt = total_r[NW-1:0];
        res_len_nxt  = NW'(1);
        res_cnt_nxt  = NW'(1);
        res_cre_nxt  = 1'b1;
        state_nxt    = ptb_pkg::S_EMIT;
      end else begin
        phase2_nxt = 1'b1;
        p_nxt      = link_p_r;
        node_raddr = link_p_r;
        state_nxt  = ptb_pkg::S_WNODE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ptb_pkg::S_IDLE;
      pos_r    <= '0;
      last_r   <= ptb_pkg::ROOT_ZERO;
      total_r  <= LW'(2);
      phase2_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      last_r   <= last_nxt;
      total_r  <= total_nxt;
      phase2_r <= phase2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    c_r        <= c_nxt;
    p_r        <= p_nxt;
    len_p_r    <= len_p_nxt;
    link_p_r   <= link_p_nxt;
    fresh_r    <= fresh_nxt;
    nl_r       <= nl_nxt;
    par_r      <= par_nxt;
    q_r        <= q_nxt;
    res_node_r <= res_node_nxt;
    res_len_r  <= res_len_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_cre_r  <= res_cre_nxt;
    res_ovf_r  <= res_ovf_nxt;
  end

  // Output register: load from the pending result, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_node_r <= res_node_r;
      out_len_r  <= res_len_r;
      out_cnt_r  <= res_cnt_r;
      out_cre_r  <= res_cre_r;
      out_ovf_r  <= res_ovf_r;
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_node_index              = out_node_r;
  assign out_palindrome_length       = out_len_r;
  assign out_suffix_palindrome_count = out_cnt_r;
  assign out_created_node            = out_cre_r;
  assign out_overflow                = out_ovf_r;

endmodule
`default_nettype wire

>>> design/ptb_checker.sv
// Port-level checker for the palindromic tree builder, bound to the top level.
// Depends on palindromic_tree_builder_top ports only.
`timescale 1ns / 1ps
`default_nettype none
module ptb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [11:0] out_node_index,
  input wire logic [11:0] out_palindrome_length,
  input wire logic [11:0] out_suffix_palindrome_count,
  input wire logic        out_created_node,
  input wire logic        out_overflow
);

  // A stalled result stays valid and keeps its node index
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_index))
    else $error("result dropped or changed while stalled");

  a_cre_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_created_node && out_overflow))
    else $error("created and overflow both set");

  a_cre_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_created_node |->
      out_palindrome_length != 12'd0 && out_suffix_palindrome_count != 12'd0 &&
      out_node_index != 12'd0 && out_node_index != 12'd1)
    else $error("created node reports a root or empty length");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_node_index == 12'd1 |->
      out_palindrome_length == 12'd0 && out_suffix_palindrome_count == 12'd0)
    else $error("empty root reports nonzero length or count");

endmodule

bind palindromic_tree_builder_top ptb_checker u_ptb_checker (
  .clk                        (clk),
  .rst_n                      (rst_n),
  .out_valid                  (out_valid),
  .out_ready                  (out_ready),
  .out_node_index             (out_node_index),
  .out_palindrome_length      (out_palindrome_length),
  .out_suffix_palindrome_count(out_suffix_palindrome_count),
  .out_created_node           (out_created_node),
  .out_overflow               (out_overflow)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for palindromic_tree_builder_top: a directed table, then
// random appends and restarts checked against an in-bench eertree predictor.
// Depends on ptb_pkg and the palindromic_tree_builder_top RTL.
`timescale 1ns / 1ps
module testbench;

  localparam int   WATCHDOG_LIMIT = 20000;
  localparam logic KIND_APPEND  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [4:0]  in_symbol = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_node_index;
  logic [11:0] out_palindrome_length;
  logic [11:0] out_suffix_palindrome_count;
  logic        out_created_node;
  logic        out_overflow;

  palindromic_tree_builder_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_symbol(in_symbol),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_node_index(out_node_index),
    .out_palindrome_length(out_palindrome_length),
    .out_suffix_palindrome_count(out_suffix_palindrome_count),
    .out_created_node(out_created_node),
    .out_overflow(out_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  typedef struct packed {
    logic [11:0] node;
    logic [11:0] len;
    logic [11:0] cnt;
    logic        created;
    logic        ovf;
  } tree_result_t;

  typedef struct {
    logic        kind;
    logic [4:0]  sym;
    logic        fixed;   // expected result typed in the table
    tree_result_t res;
  } stim_row_t;

  // Predictor state: a private copy of the eertree.
  int          pt_len [ptb_pkg::NODE_CAPACITY];
  int          pt_link [ptb_pkg::NODE_CAPACITY];
  int          pt_cnt [ptb_pkg::NODE_CAPACITY];
  int          pt_edge [int];
  int          pt_text [ptb_pkg::TEXT_CAP];
  int          pt_last, pt_total, pt_pos;

  tree_result_t pending_results[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          stim_done = 1'b0;

  function automatic void tree_clear();
    pt_edge.delete();
    pt_len[0] = -1; pt_len[1] = 0;
    pt_link[0] = 0; pt_link[1] = 0;
    pt_cnt[0] = 0; pt_cnt[1] = 0;
    pt_last = 1; pt_total = 2; pt_pos = 0;
  endfunction

  function automatic bit can_wrap(int node, int idx, int c);
    int j;
    j = idx - pt_len[node] - 1;
    if (j < 0 || j >= ptb_pkg::TEXT_CAP) return 1'b0;
    return pt_text[j] == c;
  endfunction

  function automatic int edge_of(int node, int c);
    int key;
    key = node * ptb_pkg::ALPHABET_SIZE + c;
    return pt_edge.exists(key) ? pt_edge[key] : 0;
  endfunction

  function automatic tree_result_t node_result(int node, bit created, bit ovf);
    tree_result_t r;
    r.node = node[11:0];
    r.len = (pt_len[node] < 0) ? 12'd0 : pt_len[node][11:0];
    r.cnt = (node < 2) ? 12'd0 : pt_cnt[node][11:0];
    r.created = created;
    r.ovf = ovf;
    return r;
  endfunction

  // Advance the predictor by one request and return its result.
  function automatic tree_result_t tree_step(logic kind, logic [4:0] sym);
    int c, idx, p, q, fresh;
    if (kind == KIND_RESTART) begin
      tree_clear();
      return node_result(1, 1'b0, 1'b0);
    end
    if (pt_pos >= ptb_pkg::TEXT_CAP || pt_total >= ptb_pkg::NODE_CAPACITY)
      return node_result(pt_last, 1'b0, 1'b1);
    c = int'(sym) % ptb_pkg::ALPHABET_SIZE;
    idx = pt_pos;
    pt_text[idx] = c;
    pt_pos++;
    p = pt_last;
    while (!can_wrap(p, idx, c)) p = pt_link[p];
    q = edge_of(p, c);
    if (q != 0) begin
      pt_last = q;
      return node_result(q, 1'b0, 1'b0);
    end
    fresh = pt_total;
    pt_total++;
    pt_len[fresh] = pt_len[p] + 2;
    for (int s = 0; s < ptb_pkg::ALPHABET_SIZE; s++)
      pt_edge.delete(fresh * ptb_pkg::ALPHABET_SIZE + s);
    pt_edge[p * ptb_pkg::ALPHABET_SIZE + c] = fresh;
    pt_last = fresh;
    if (pt_len[fresh] == 1) begin
      pt_link[fresh] = 1;
      pt_cnt[fresh] = 1;
    end else begin
      do p = pt_link[p]; while (!can_wrap(p, idx, c));
      q = edge_of(p, c);
      pt_link[fresh] = q;
      pt_cnt[fresh] = ((q < 2) ? 0 : pt_cnt[q]) + 1;
    end
    return node_result(fresh, 1'b1, 1'b0);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Hold each request until accepted; drop valid only for an idle gap between requests.
  task automatic send_request(logic kind, logic [4:0] sym, bit fixed, tree_result_t fixed_res);
    tree_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_symbol <= sym;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = tree_step(kind, sym);
    if (fixed) begin
      if (r != fixed_res) report_mismatch("table row vs predictor", r.node, fixed_res.node);
      r = fixed_res;
    end
    pending_results.push_back(r);
  endtask

  // Receiver: random stalls, compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    tree_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result node", out_node_index, -1);
        end else begin
          want = pending_results.pop_front();
          if (out_node_index !== want.node)
            report_mismatch("node_index", out_node_index, want.node);
          if (out_palindrome_length !== want.len)
            report_mismatch("palindrome_length", out_palindrome_length, want.len);
          if (out_suffix_palindrome_count !== want.cnt)
            report_mismatch("suffix_palindrome_count", out_suffix_palindrome_count, want.cnt);
          if (out_created_node !== want.created)
            report_mismatch("created_node", out_created_node, want.created);
          if (out_overflow !== want.ovf)
            report_mismatch("overflow", out_overflow, want.ovf);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (rst_n && (!stim_done || pending_results.size() != 0)) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic tree_result_t mk(int node, int len, int cnt, bit cr, bit ov);
    tree_result_t r;
    r.node = 12'(node); r.len = 12'(len); r.cnt = 12'(cnt); r.created = cr; r.ovf = ov;
    return r;
  endfunction

  function automatic stim_row_t row(logic kind, logic [4:0] sym, bit fixed, tree_result_t r);
    stim_row_t s;
    s.kind = kind; s.sym = sym; s.fixed = fixed; s.res = r;
    return s;
  endfunction

  // Random phase: mostly palindrome-rich strings over a small alphabet.
  task automatic random_phase(int count, int s_idle, int r_stall);
    int alpha;
    logic [4:0] sym;
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    alpha = 2;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) begin
        send_request(KIND_RESTART, 5'($urandom), 1'b0, mk(0, 0, 0, 0, 0));
        alpha = $urandom_range(1, 4);
      end else begin
        if ($urandom_range(99) < 15) sym = 5'($urandom);
        else sym = 5'($urandom_range(alpha - 1));
        send_request(KIND_APPEND, sym, 1'b0, mk(0, 0, 0, 0, 0));
      end
    end
  endtask

  stim_row_t directed[$];
  tree_result_t none;

  initial begin
    none = mk(0, 0, 0, 0, 0);
    tree_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    out_ready <= 1'b1;

    // Restart result is fixed; single symbols and extremes are easy to read off.
    directed.push_back(row(KIND_RESTART, 5'd0, 1'b1, mk(1, 0, 0, 0, 0)));
    directed.push_back(row(KIND_APPEND, 5'd31, 1'b1, mk(2, 1, 1, 1, 0)));
    directed.push_back(row(KIND_APPEND, 5'd31, 1'b1, mk(3, 2, 2, 1, 0)));
    directed.push_back(row(KIND_APPEND, 5'd31, 1'b1, mk(4, 3, 3, 1, 0)));
    directed.push_back(row(KIND_RESTART, 5'd31, 1'b1, mk(1, 0, 0, 0, 0)));
    directed.push_back(row(KIND_APPEND, 5'd0, 1'b1, mk(2, 1, 1, 1, 0)));
    directed.push_back(row(KIND_APPEND, 5'd21, 1'b0, none));
    directed.push_back(row(KIND_APPEND, 5'd10, 1'b0, none));
    directed.push_back(row(KIND_APPEND, 5'd21, 1'b0, none));
    directed.push_back(row(KIND_APPEND, 5'd0, 1'b0, none));
    directed.push_back(row(KIND_APPEND, 5'd0, 1'b0, none));
    directed.push_back(row(KIND_APPEND, 5'd21, 1'b0, none));
    directed.push_back(row(KIND_APPEND, 5'd10, 1'b0, none));
    directed.push_back(row(KIND_APPEND, 5'd21, 1'b0, none));
    directed.push_back(row(KIND_APPEND, 5'd0, 1'b0, none));
    directed.push_back(row(KIND_APPEND, 5'd31, 1'b0, none));
    directed.push_back(row(KIND_RESTART, 5'd21, 1'b1, mk(1, 0, 0, 0, 0)));
    foreach (directed[k])
      send_request(directed[k].kind, directed[k].sym, directed[k].fixed, directed[k].res);

    random_phase(90, 0, 0);
    random_phase(90, 69, 0);
    random_phase(90, 0, 69);
    random_phase(90, 30, 30);

    send_request(KIND_RESTART, 5'd0, 1'b1, mk(1, 0, 0, 0, 0));
    random_phase(20, 30, 30);

    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
